### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file lpcp_check.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define LPCP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define LPCP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/lpcp_pkg.sv
// Types and constants of the lidar point painting block.
`default_nettype none
package lpcp_pkg;

  // register indices of the configuration port
  localparam logic [2:0] REG_ROT0   = 3'd0;
  localparam logic [2:0] REG_ROT1   = 3'd1;
  localparam logic [2:0] REG_ROT2   = 3'd2;
  localparam logic [2:0] REG_TRANS  = 3'd3;
  localparam logic [2:0] REG_FOCAL  = 3'd4;
  localparam logic [2:0] REG_CENTER = 3'd5;
  localparam logic [2:0] REG_ISIZE  = 3'd6;

  localparam int CFG_W = 60;  // widest register

  localparam logic [53:0] ROT0_RST  = 54'd65536;
  localparam logic [53:0] ROT1_RST  = 54'd17179869184;
  localparam logic [53:0] ROT2_RST  = 54'd4503599627370496;
  localparam logic [21:0] ISIZE_RST = 22'd1311360;

  // command codes
  localparam logic CMD_MASK  = 1'b0;
  localparam logic CMD_POINT = 1'b1;

  // datapath widths
  localparam int NUM_W = 60;  // rounded numerator 2|n| + 256z
  localparam int DEN_W = 42;  // denominator 512z

  typedef struct packed {
    logic               cmd;
    logic [9:0]         mask_col;
    logic [9:0]         mask_row;
    logic [15:0]        mask_class;
    logic [15:0]        mask_conf;
    logic signed [23:0] pt_x;
    logic signed [23:0] pt_y;
    logic signed [23:0] pt_z;
    logic [15:0]        pt_intensity;
  } item_t;

  typedef struct packed {
    logic signed [23:0] out_x;
    logic signed [23:0] out_y;
    logic signed [23:0] out_z;
    logic [15:0]        out_intensity;
    logic [15:0]        paint_cls;
    logic [15:0]        paint_conf;
    logic               painted;
    logic               in_view;
    logic [9:0]         img_u;
    logic [9:0]         img_v;
  } result_t;

endpackage
`default_nettype wire

### hw/rtl/lpcp_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module lpcp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/lpcp_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
`default_nettype none
module lpcp_div #(
  parameter int QB = 10
) (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [lpcp_pkg::NUM_W-1:0]   num,
  input  wire logic [lpcp_pkg::DEN_W-1:0]   den,
  output logic      [QB-1:0]                quo,
  output logic                              ovf
);
  import lpcp_pkg::*;

  logic [NUM_W-1:0] rem [QB];
  logic [DEN_W-1:0] dd  [QB];
  logic [QB-1:0]    qq  [QB+1];
  logic             ov  [QB+1];

  // entry stage: register the operands and flag a quotient too large for QB bits
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num;
      dd[0]  <= den;
      qq[0]  <= '0;
      ov[0]  <= (num >= (NUM_W'(den) << QB));
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_stage
    logic [NUM_W-1:0] sh;
    logic             ge;
    assign sh = NUM_W'(dd[k-1]) << (QB - k);
    assign ge = (rem[k-1] >= sh);
    always_ff @(posedge clk) begin
      if (en) begin
        ov[k] <= ov[k-1];
        qq[k] <= qq[k-1] | (ge ? (QB'(1) << (QB - k)) : '0);
      end
    end
    // last stage only needs its quotient bit
    if (k < QB) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k] <= ge ? (rem[k-1] - sh) : rem[k-1];
          dd[k]  <= dd[k-1];
        end
      end
    end
  end

  assign quo = qq[QB];
  assign ovf = ov[QB];

endmodule
`default_nettype wire

### hw/rtl/lidar_point_camera_paint_top.sv
// Throughput: one item per cycle; the whole pipeline, the mask RAM port included, stalls only
// when a result is held and not taken. Mask writes go down the same pipe and give no result.
// The mask RAM has one port: a stage either writes a mask pixel or reads one for a point.
// Reset: synchronous; clears valid bits and loads register defaults. Mask RAM is not cleared.
`default_nettype none
module lidar_point_camera_paint_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         item_valid,
  output logic                              item_ready,
  input  wire lpcp_pkg::item_t              item,
  output logic                              result_valid,
  input  wire logic                         result_ready,
  output lpcp_pkg::result_t                 result,
  input  wire logic                         cfg_we,
  input  wire logic [2:0]                   cfg_index,
  input  wire logic [lpcp_pkg::CFG_W-1:0]   cfg_data
);
  import lpcp_pkg::*;

  localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int QB      = $clog2(MAX_DIM);              // quotient bits
  localparam int CW      = ((QB > 11) ? QB : 11) + 1;    // compare width
  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW      = $clog2(DEPTH);

  // sideband carried alongside the arithmetic
  typedef struct packed {
    logic               vld;
    logic               pt;
    logic               zpos;
    logic               negu;
    logic               negv;
    logic [9:0]         col;
    logic [9:0]         row;
    logic [15:0]        cls;
    logic [15:0]        conf;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic [15:0]        inten;
  } sb_t;

  // ---------------- configuration registers ----------------
  logic [53:0] rot0, rot1, rot2;
  logic [59:0] trans;
  logic [47:0] focal, center;
  logic [21:0] isize;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot0   <= ROT0_RST;
      rot1   <= ROT1_RST;
      rot2   <= ROT2_RST;
      trans  <= '0;
      focal  <= '0;
      center <= '0;
      isize  <= ISIZE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROT0:   rot0   <= cfg_data[53:0];
        REG_ROT1:   rot1   <= cfg_data[53:0];
        REG_ROT2:   rot2   <= cfg_data[53:0];
        REG_TRANS:  trans  <= cfg_data[59:0];
        REG_FOCAL:  focal  <= cfg_data[47:0];
        REG_CENTER: center <= cfg_data[47:0];
        REG_ISIZE:  isize  <= cfg_data[21:0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  // one global advance; the output register is the only place a result waits
  logic adv;
  assign adv        = !result_valid || result_ready;
  assign item_ready = adv && !rst;

  // ---------------- s1: input register ----------------
  sb_t s1;
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.vld <= 1'b0;
    end else if (adv) begin
      s1.vld   <= item_valid;
      s1.pt    <= (item.cmd == CMD_POINT);
      s1.zpos  <= 1'b0;
      s1.negu  <= 1'b0;
      s1.negv  <= 1'b0;
      s1.col   <= item.mask_col;
      s1.row   <= item.mask_row;
      s1.cls   <= item.mask_class;
      s1.conf  <= item.mask_conf;
      s1.x     <= item.pt_x;
      s1.y     <= item.pt_y;
      s1.z     <= item.pt_z;
      s1.inten <= item.pt_intensity;
    end
  end

  // ---------------- s2: rotation products ----------------
  logic [53:0] rows [3];
  assign rows[0] = rot0;
  assign rows[1] = rot1;
  assign rows[2] = rot2;

  logic signed [23:0] pin [3];
  assign pin[0] = s1.x;
  assign pin[1] = s1.y;
  assign pin[2] = s1.z;

  sb_t s2;
  logic signed [41:0] prod [3][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.vld <= 1'b0;
    end else if (adv) begin
      s2 <= s1;
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      always_ff @(posedge clk) begin
        if (adv) begin
          prod[r][c] <= $signed(rows[r][18*c +: 18]) * pin[c];
        end
      end
    end
  end

  // ---------------- s3: sum, translate, floor to Q.16 m ----------------
  logic signed [43:0] acc [3];
  logic signed [33:0] cam [3];
  sb_t s3, s3_next;
  logic signed [33:0] xc, yc, zc;

  for (genvar r = 0; r < 3; r++) begin : g_acc
    assign acc[r] = (44'($signed(trans[20*r +: 20])) <<< 16) + 44'(prod[r][0])
                    + 44'(prod[r][1]) + 44'(prod[r][2]);
    assign cam[r] = 34'(acc[r] >>> 10);
  end

  // depth counts as positive from one LSB of Q.16 m upwards
  always_comb begin
    s3_next      = s2;
    s3_next.zpos = !cam[2][33] && (cam[2] != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3.vld <= 1'b0;
    end else if (adv) begin
      s3 <= s3_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xc <= cam[0];
      yc <= cam[1];
      zc <= cam[2];
    end
  end

  // ---------------- s4: projection partial products ----------------
  // 24 x 34 bit products split at bit 17 of the camera coordinate
  logic [23:0] fx, fy, cx, cy;
  assign fx = focal[23:0];
  assign fy = focal[47:24];
  assign cx = center[23:0];
  assign cy = center[47:24];

  sb_t s4;
  logic [40:0]        pfxl, pfyl, pcxl, pcyl;
  logic signed [41:0] pfxh, pfyh, pcxh, pcyh;
  logic signed [33:0] zc4;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4.vld <= 1'b0;
    end else if (adv) begin
      s4 <= s3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pfxl <= fx * xc[16:0];
      pfyl <= fy * yc[16:0];
      pcxl <= cx * zc[16:0];
      pcyl <= cy * zc[16:0];
      pfxh <= $signed(xc[33:17]) * $signed({1'b0, fx});
      pfyh <= $signed(yc[33:17]) * $signed({1'b0, fy});
      pcxh <= $signed(zc[33:17]) * $signed({1'b0, cx});
      pcyh <= $signed(zc[33:17]) * $signed({1'b0, cy});
      zc4  <= zc;
    end
  end

  // ---------------- s5: numerators f*c + c0*z ----------------
  sb_t s5;
  logic signed [59:0] nu, nv;
  logic signed [33:0] zc5;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5.vld <= 1'b0;
    end else if (adv) begin
      s5 <= s4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nu  <= (60'(pfxh) << 17) + 60'(pfxl) + (60'(pcxh) << 17) + 60'(pcxl);
      nv  <= (60'(pfyh) << 17) + 60'(pfyl) + (60'(pcyh) << 17) + 60'(pcyl);
      zc5 <= zc4;
    end
  end

  // ---------------- s6: rounding form (2|n| + d) / 2d ----------------
  sb_t s6, s6_next;
  logic [NUM_W-1:0] numu, numv;
  logic [DEN_W-1:0] den;
  logic [NUM_W-1:0] magu, magv;

  assign magu = nu[59] ? NUM_W'(-nu) : NUM_W'(nu);
  assign magv = nv[59] ? NUM_W'(-nv) : NUM_W'(nv);

  // signs ride along to the view test, where a negative quotient counts only if it rounds to zero
  always_comb begin
    s6_next      = s5;
    s6_next.negu = nu[59];
    s6_next.negv = nv[59];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s6.vld <= 1'b0;
    end else if (adv) begin
      s6 <= s6_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      numu <= (magu << 1) + (NUM_W'(zc5) << 8);
      numv <= (magv << 1) + (NUM_W'(zc5) << 8);
      den  <= DEN_W'(zc5) << 9;
    end
  end

  // ---------------- dividers, one lane per image axis ----------------
  logic [QB-1:0] qu, qv;
  logic          ovu, ovv;

  lpcp_div #(.QB(QB)) u_div_u (
    .clk (clk), .en (adv), .num (numu), .den (den), .quo (qu), .ovf (ovu)
  );

  lpcp_div #(.QB(QB)) u_div_v (
    .clk (clk), .en (adv), .num (numv), .den (den), .quo (qv), .ovf (ovv)
  );

  // sideband delay matching the divider latency
  sb_t dsb [QB+1];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= QB; k++) begin
        dsb[k].vld <= 1'b0;
      end
    end else if (adv) begin
      dsb[0] <= s6;
      for (int k = 1; k <= QB; k++) begin
        dsb[k] <= dsb[k-1];
      end
    end
  end

  // ---------------- view test and mask RAM access ----------------
  sb_t           dl;
  logic [CW-1:0] wcap, hcap;
  logic          okU, okV, inview, wr_ok;
  logic [AW-1:0] rd_addr, wr_addr, ram_addr;
  logic          ram_en, ram_we;
  logic [31:0]   ram_rdata;

  assign dl = dsb[QB];

  // a negative quotient is in range only when it rounds to zero
  assign wcap   = (CW'(isize[10:0]) < CW'(MAX_WIDTH))  ? CW'(isize[10:0])  : CW'(MAX_WIDTH);
  assign hcap   = (CW'(isize[21:11]) < CW'(MAX_HEIGHT)) ? CW'(isize[21:11]) : CW'(MAX_HEIGHT);
  assign okU    = !ovu && (!dl.negu || (qu == '0)) && (CW'(qu) < wcap);
  assign okV    = !ovv && (!dl.negv || (qv == '0)) && (CW'(qv) < hcap);
  assign inview = dl.zpos && okU && okV;

  assign wr_ok  = (32'(dl.col) < 32'(MAX_WIDTH)) && (32'(dl.row) < 32'(MAX_HEIGHT));
  assign rd_addr = AW'(AW'(qv) * AW'(MAX_WIDTH) + AW'(qu));
  assign wr_addr = AW'(AW'(dl.row) * AW'(MAX_WIDTH) + AW'(dl.col));

  assign ram_we   = !dl.pt;
  assign ram_en   = adv && dl.vld && (dl.pt ? inview : wr_ok);
  assign ram_addr = dl.pt ? rd_addr : wr_addr;

  lpcp_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_mask (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata ({dl.conf, dl.cls}),
    .rdata (ram_rdata)
  );

  // ---------------- s7: aligned with RAM read data ----------------
  sb_t        s7;
  logic       s7_view;
  logic [9:0] s7_u, s7_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7.vld <= 1'b0;
    end else if (adv) begin
      s7 <= dl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_view <= inview;
      s7_u    <= inview ? 10'(qu) : '0;
      s7_v    <= inview ? 10'(qv) : '0;
    end
  end

  // ---------------- output register ----------------
  logic paint;
  assign paint = s7_view && (ram_rdata[15:0] != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= s7.vld && s7.pt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.out_x         <= s7.x;
      result.out_y         <= s7.y;
      result.out_z         <= s7.z;
      result.out_intensity <= s7.inten;
      result.paint_cls     <= paint ? ram_rdata[15:0]  : '0;
      result.paint_conf    <= paint ? ram_rdata[31:16] : '0;
      result.painted       <= paint;
      result.in_view       <= s7_view;
      result.img_u         <= s7_u;
      result.img_v         <= s7_v;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/lpcp_check.sv
// Port-level checker for the painting block, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module lpcp_check (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              result_valid,
  input wire logic              result_ready,
  input wire lpcp_pkg::result_t result
);

  `LPCP_ASSERT(a_paint_view, clk, rst, result_valid && result.painted |-> result.in_view, "painted point not in view")
  `LPCP_ASSERT(a_out_view, clk, rst, result_valid && !result.in_view |-> result.img_u == 0 && result.img_v == 0 && result.paint_cls == 0 && result.paint_conf == 0, "out of view with pixel or paint")
  `LPCP_ASSERT(a_paint_cls, clk, rst, result_valid |-> result.painted == (result.paint_cls != 0), "painted flag disagrees with class")
  `LPCP_ASSERT(a_hold, clk, rst, result_valid && !result_ready |=> result_valid && $stable(result), "stalled result changed")
  `LPCP_ASSERT_ALWAYS(a_rst, clk, rst |=> !result_valid, "result valid after reset")

endmodule

bind lidar_point_camera_paint_top lpcp_check u_check (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
`default_nettype wire
